@@ hw/rtl/nearest_wall_ray_cast_assert.svh @@
// assertion macros shared by the ray cast block
`ifndef NEAREST_WALL_RAY_CAST_ASSERT_SVH
`define NEAREST_WALL_RAY_CAST_ASSERT_SVH

// property must hold at every clock edge out of reset
`define NWRC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a signal must stay low
`define NWRC_NEVER(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(sig)) else $error(msg);

`endif

@@ hw/rtl/nwrc_pkg.sv @@
//------------------------------------------------------------------------------
// nwrc_pkg
// shared types and constants of the nearest wall ray cast block
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package nwrc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DirW   = 16;
  localparam int unsigned CountW = 9;
  localparam int unsigned IndexW = 8;
  localparam int unsigned DistW  = 32;
  // extended precision for the distance divide
  localparam int unsigned NumW   = 100;
  localparam int unsigned DenW   = 52;

  localparam logic OpWrite = 1'b0;
  localparam logic OpCast  = 1'b1;

  localparam logic [1:0] RegWallCount = 2'd0;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StFetch = 5'b00010,
    StTest  = 5'b00100,
    StDiv   = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_ray;   // capture ray and clear best
    logic read_wall;  // issue table read
    logic test;       // evaluate current wall
    logic div_start;  // begin divide
    logic div_step;   // one quotient bit
    logic commit;     // compare and keep best
    logic publish;    // copy best into the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cand;       // wall is a hit candidate
    logic sat;        // distance saturates
    logic div_last;   // last quotient bit this cycle
  } dp_sts_t;

endpackage

@@ hw/rtl/nwrc_ctrl.sv @@
//------------------------------------------------------------------------------
// nwrc_ctrl
// sequencer: walks the wall table for each cast and drives the datapath
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module nwrc_ctrl #(
  parameter int unsigned MaxWalls = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_op_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic [nwrc_pkg::CountW-1:0]   wall_count_i,
  output logic [$clog2(MaxWalls+1)-1:0] idx_o,
  output nwrc_pkg::dp_cmd_t             cmd_o,
  input  nwrc_pkg::dp_sts_t             sts_i
);

  localparam int unsigned IdxW = $clog2(MaxWalls + 1);
  localparam int unsigned CmpW = (IdxW > nwrc_pkg::CountW) ? IdxW : nwrc_pkg::CountW;

  nwrc_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [CmpW-1:0]  limit;
  logic             out_valid_q, out_valid_d;
  logic             take;

  always_comb begin
    if (CmpW'(wall_count_i) > CmpW'(MaxWalls)) begin
      limit = CmpW'(MaxWalls);
    end else begin
      limit = CmpW'(wall_count_i);
    end
  end

  assign in_ready_o  = (state_q == nwrc_pkg::StIdle);
  assign out_valid_o = out_valid_q;
  assign idx_o       = idx_q;
  assign take        = in_valid_i && in_ready_o && (in_op_i == nwrc_pkg::OpCast);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      nwrc_pkg::StIdle: begin
        if (take) begin
          cmd_o.load_ray = 1'b1;
          idx_d          = '0;
          state_d        = nwrc_pkg::StFetch;
        end
      end
      nwrc_pkg::StFetch: begin
        if (CmpW'(idx_q) >= limit) begin
          state_d = nwrc_pkg::StOut;
        end else begin
          cmd_o.read_wall = 1'b1;
          state_d         = nwrc_pkg::StTest;
        end
      end
      nwrc_pkg::StTest: begin
        cmd_o.test = 1'b1;
        if (sts_i.cand && !sts_i.sat) begin
          cmd_o.div_start = 1'b1;
          state_d         = nwrc_pkg::StDiv;
        end else begin
          cmd_o.commit = sts_i.cand;
          idx_d        = idx_q + 1'b1;
          state_d      = nwrc_pkg::StFetch;
        end
      end
      nwrc_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.commit = 1'b1;
          idx_d        = idx_q + 1'b1;
          state_d      = nwrc_pkg::StFetch;
        end
      end
      nwrc_pkg::StOut: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = nwrc_pkg::StIdle;
        end
      end
      default: begin
        state_d = nwrc_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nwrc_pkg::StIdle;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/nwrc_dp.sv @@
//------------------------------------------------------------------------------
// nwrc_dp
// wall table, cross products, restoring divider and best hit tracking
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module nwrc_dp #(
  parameter int unsigned MaxWalls = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [nwrc_pkg::IndexW-1:0]       wr_slot_i,
  input  logic signed [nwrc_pkg::CoordW-1:0] start_x_i,
  input  logic signed [nwrc_pkg::CoordW-1:0] start_y_i,
  input  logic signed [nwrc_pkg::CoordW-1:0] end_x_i,
  input  logic signed [nwrc_pkg::CoordW-1:0] end_y_i,
  input  logic signed [nwrc_pkg::CoordW-1:0] origin_x_i,
  input  logic signed [nwrc_pkg::CoordW-1:0] origin_y_i,
  input  logic signed [nwrc_pkg::DirW-1:0]  dir_x_i,
  input  logic signed [nwrc_pkg::DirW-1:0]  dir_y_i,
  input  logic [$clog2(MaxWalls+1)-1:0]     idx_i,
  input  nwrc_pkg::dp_cmd_t                 cmd_i,
  output nwrc_pkg::dp_sts_t                 sts_o,
  output logic                              hit_o,
  output logic [nwrc_pkg::IndexW-1:0]       hit_index_o,
  output logic [nwrc_pkg::DistW-1:0]        distance_o
);

  localparam int unsigned AddrW = (MaxWalls > 1) ? $clog2(MaxWalls) : 1;
  localparam int unsigned IdxW  = $clog2(MaxWalls + 1);
  localparam int unsigned CW    = nwrc_pkg::CoordW;
  localparam int unsigned NW    = nwrc_pkg::NumW;
  localparam int unsigned DW    = nwrc_pkg::DenW;

  logic [4*CW-1:0] mem [MaxWalls];
  logic [4*CW-1:0] rd_q;

  logic signed [CW-1:0]     ox_q, oy_q;
  logic signed [nwrc_pkg::DirW-1:0] dx_q, dy_q;

  logic signed [CW:0]   ax, ay, ex, ey;
  logic signed [CW+nwrc_pkg::DirW+1:0] den, num_u, dn, nu;
  // 33x33 products feed the test compare in the test cycle
  logic signed [2*CW+2:0] p_ae, p_ay, num_t, nt;
  logic                   cand, sat;

  logic [NW-1:0]  rem_q;
  logic [DW-1:0]  dsr_q;
  logic [4:0]     bit_q;
  logic [nwrc_pkg::DistW-1:0] quo_q;
  logic [NW-1:0]  dshift;
  logic [nwrc_pkg::DistW-1:0] q_val;

  logic           found_q;
  logic [nwrc_pkg::IndexW-1:0] best_idx_q;
  logic [nwrc_pkg::DistW-1:0]  best_dist_q;
  logic           sat_q;

  logic                        res_hit_q;
  logic [nwrc_pkg::IndexW-1:0] res_idx_q;
  logic [nwrc_pkg::DistW-1:0]  res_dist_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (32'(wr_slot_i) < MaxWalls)) begin
      mem[wr_slot_i[AddrW-1:0]] <= {start_x_i, start_y_i, end_x_i, end_y_i};
    end
    if (cmd_i.read_wall) begin
      rd_q <= mem[idx_i[AddrW-1:0]];
    end
  end

  always_comb begin
    ax    = $signed({rd_q[4*CW-1], rd_q[4*CW-1:3*CW]}) - $signed({ox_q[CW-1], ox_q});
    ay    = $signed({rd_q[3*CW-1], rd_q[3*CW-1:2*CW]}) - $signed({oy_q[CW-1], oy_q});
    ex    = $signed({rd_q[2*CW-1], rd_q[2*CW-1:CW]}) -
            $signed({rd_q[4*CW-1], rd_q[4*CW-1:3*CW]});
    ey    = $signed({rd_q[CW-1], rd_q[CW-1:0]}) -
            $signed({rd_q[3*CW-1], rd_q[3*CW-1:2*CW]});
    den   = (CW+nwrc_pkg::DirW+2)'(dx_q * ey) - (CW+nwrc_pkg::DirW+2)'(dy_q * ex);
    num_u = (CW+nwrc_pkg::DirW+2)'(ax * dy_q) - (CW+nwrc_pkg::DirW+2)'(ay * dx_q);
    p_ae  = (2*CW+3)'(ax * ey);
    p_ay  = (2*CW+3)'(ay * ex);
    num_t = p_ae - p_ay;
    if (den < 0) begin
      dn = -den;
      nu = -num_u;
      nt = -num_t;
    end else begin
      dn = den;
      nu = num_u;
      nt = num_t;
    end
    cand = (den != 0) && (nt >= 0) && (nu >= 0) && (nu <= dn);
    // quotient would not fit in 32 bits
    sat  = ((2*CW+3+18)'(nt) >= ((2*CW+3+18)'(dn) << 18));
  end

  assign sts_o.cand     = cand;
  assign sts_o.sat      = sat;
  assign sts_o.div_last = (bit_q == 5'd0);

  assign dshift = NW'(dsr_q) << bit_q;
  assign q_val  = sat_q ? '1 : quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_ray) begin
      ox_q <= origin_x_i;
      oy_q <= origin_y_i;
      dx_q <= dir_x_i;
      dy_q <= dir_y_i;
    end
    if (cmd_i.test) begin
      sat_q <= sat;
    end
    if (cmd_i.div_start) begin
      rem_q <= NW'(nt) << 14;
      dsr_q <= DW'(dn);
      bit_q <= 5'd31;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= dshift) begin
        rem_q <= rem_q - dshift;
        quo_q[bit_q] <= 1'b1;
      end
      bit_q <= bit_q - 1'b1;
    end
  end

  // the final quotient bit lands in the same cycle as commit
  logic [nwrc_pkg::DistW-1:0] q_fin;
  always_comb begin
    q_fin = q_val;
    if (cmd_i.div_step && !sat_q && (rem_q >= dshift)) begin
      q_fin[bit_q] = 1'b1;
    end
    if (cmd_i.test) begin
      q_fin = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_dist_q <= '1;
    end else if (cmd_i.load_ray) begin
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_dist_q <= '1;
    end else if (cmd_i.commit) begin
      if (!found_q || (q_fin < best_dist_q)) begin
        found_q     <= 1'b1;
        best_idx_q  <= idx_i[nwrc_pkg::IndexW-1:0];
        best_dist_q <= q_fin;
      end
    end
  end

  // result register, so the next cast can run while a beat waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_hit_q  <= 1'b0;
      res_idx_q  <= '0;
      res_dist_q <= '1;
    end else if (cmd_i.publish) begin
      res_hit_q  <= found_q;
      res_idx_q  <= best_idx_q;
      res_dist_q <= best_dist_q;
    end
  end

  assign hit_o       = res_hit_q;
  assign hit_index_o = res_idx_q;
  assign distance_o  = res_dist_q;

  logic unused_idx;
  assign unused_idx = ^idx_i[IdxW-1:0];

endmodule

@@ hw/rtl/nearest_wall_ray_cast.sv @@
//------------------------------------------------------------------------------
// nearest_wall_ray_cast
// casts a ray against a table of wall segments and reports the nearest hit
//------------------------------------------------------------------------------
// channel  | direction | fields
// in       | input     | op, wall_slot, start/end xy, origin xy, dir xy
// out      | output    | hit, hit_index, distance
// apb      | input     | wall_count at address 0
//
// a write beat gives no result
// a cast tests each wall in turn; a hit below saturation also runs the
// one-bit-per-cycle restoring divider
// the result register holds the result until taken; the next cast runs
// meanwhile and waits in its output state, and input stalls until it leaves
// reset clears state and wall_count; the table is undefined until written
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nearest_wall_ray_cast_assert.svh"

module nearest_wall_ray_cast #(
  parameter int unsigned MAX_WALLS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                op_i,
  input  logic [7:0]          wall_slot_i,
  input  logic signed [31:0]  start_x_i,
  input  logic signed [31:0]  start_y_i,
  input  logic signed [31:0]  end_x_i,
  input  logic signed [31:0]  end_y_i,
  input  logic signed [31:0]  origin_x_i,
  input  logic signed [31:0]  origin_y_i,
  input  logic signed [15:0]  dir_x_i,
  input  logic signed [15:0]  dir_y_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                hit_o,
  output logic [7:0]          hit_index_o,
  output logic [31:0]         distance_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IdxW = $clog2(MAX_WALLS + 1);

  logic [nwrc_pkg::CountW-1:0] wall_count_q;
  nwrc_pkg::dp_cmd_t           cmd;
  nwrc_pkg::dp_sts_t           sts;
  logic [IdxW-1:0]             idx;
  logic                        wr_en;

  assign pready = 1'b1;
  assign prdata = (paddr == {nwrc_pkg::RegWallCount}) ? 32'(wall_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_count_q <= '0;
    end else if (psel && penable && pwrite && (paddr == nwrc_pkg::RegWallCount)) begin
      wall_count_q <= pwdata[nwrc_pkg::CountW-1:0];
    end
  end

  assign wr_en = in_valid_i && in_ready_o && (op_i == nwrc_pkg::OpWrite);

  nwrc_ctrl #(.MaxWalls(MAX_WALLS)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_op_i      (op_i),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .wall_count_i (wall_count_q),
    .idx_o        (idx),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  nwrc_dp #(.MaxWalls(MAX_WALLS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_slot_i   (wall_slot_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .origin_x_i  (origin_x_i),
    .origin_y_i  (origin_y_i),
    .dir_x_i     (dir_x_i),
    .dir_y_i     (dir_y_i),
    .idx_i       (idx),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .hit_o       (hit_o),
    .hit_index_o (hit_index_o),
    .distance_o  (distance_o)
  );

  // a miss reports all ones
  `NWRC_ASSERT(a_miss_dist, clk_i, rst_ni,
    (out_valid_o && !hit_o) |-> (distance_o == '1 && hit_index_o == '0),
    "miss result not all ones")
  // input is never ready while a cast tests a wall or steps the divider
  `NWRC_NEVER(a_ready_busy, clk_i, rst_ni, in_ready_o && (cmd.test || cmd.div_step),
    "ready while a cast is running")
  // divider start and step never overlap
  `NWRC_NEVER(a_div_overlap, clk_i, rst_ni, cmd.div_start && cmd.div_step,
    "divider start during step")

endmodule
